// File: rtl/dsch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsch_pkg: shared types and codes
// Transaction payload structs, operation codes and status codes for the
// deferred event scheduler.
// ----------------------------------------------------------------------------
package dsch_pkg;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_REG_AT    = 2'd1;
	localparam logic [1:0] OP_REG_AFTER = 2'd2;
	localparam logic [1:0] OP_CANCEL    = 2'd3;

	localparam logic [2:0] ST_ACCEPT = 3'd0;
	localparam logic [2:0] ST_FIRED  = 3'd1;
	localparam logic [2:0] ST_NONE   = 3'd2;
	localparam logic [2:0] ST_REJECT = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] tick_value;
		logic [15:0] payload;
		logic [5:0]  slot;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] due_tick;
		logic [5:0]  slot_out;
		logic [15:0] payload_out;
		logic        last;
	} result_t;

endpackage

// File: rtl/dsch_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsch_entry_mem: event table storage
// Due tick, slot, payload and cancel mark per entry in arrays with one
// write and one registered read per cycle; valid bits in flops.
// ----------------------------------------------------------------------------
module dsch_entry_mem #(
	parameter int DEPTH = 32,
	parameter int TW    = 32,
	parameter int SW    = 6,
	parameter int IW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output logic          rd_valid,
	output logic [TW-1:0] rd_due,
	output logic [SW-1:0] rd_slot,
	output logic [15:0]   rd_payload,
	output logic          rd_cancel,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_idx,
	input  logic [TW-1:0] wr_due,
	input  logic [SW-1:0] wr_slot,
	input  logic [15:0]   wr_payload,
	input  logic          cancel_en,
	input  logic [IW-1:0] cancel_idx,
	input  logic          free_en,
	input  logic [IW-1:0] free_idx
);

	logic [TW-1:0]    due_mem     [DEPTH];
	logic [SW-1:0]    slot_mem    [DEPTH];
	logic [15:0]      payload_mem [DEPTH];
	logic             cancel_mem  [DEPTH];
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			due_mem[wr_idx]     <= wr_due;
			slot_mem[wr_idx]    <= wr_slot;
			payload_mem[wr_idx] <= wr_payload;
		end
		if (wr_en) begin
			cancel_mem[wr_idx] <= 1'b0;
		end else if (cancel_en) begin
			cancel_mem[cancel_idx] <= 1'b1;
		end
		rd_due     <= due_mem[rd_idx];
		rd_slot    <= slot_mem[rd_idx];
		rd_payload <= payload_mem[rd_idx];
		rd_cancel  <= cancel_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
			if (free_en)
				valid_q[free_idx] <= 1'b0;
			rd_valid <= valid_q[rd_idx];
		end
	end

endmodule

// File: rtl/dsch_slot_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsch_slot_map: slot-ordered fire buffer
// Indexed by slot minus one; holds the payload and a live flag for each
// entry found due during a tick scan. Registered read.
// ----------------------------------------------------------------------------
module dsch_slot_map #(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic          wr_live,
	input  logic [15:0]   wr_payload,
	input  logic [IW-1:0] rd_addr,
	output logic          rd_live,
	output logic [15:0]   rd_payload
);

	logic [16:0] map_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			map_mem[wr_addr] <= {wr_live, wr_payload};
		{rd_live, rd_payload} <= map_mem[rd_addr];
	end

endmodule

// File: rtl/deferred_event_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deferred_event_scheduler_top: timer event queue
// Pending event table with register, cancel and tick operations.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and pulse start while busy is low; the
//   transaction is taken at that edge and busy rises the next cycle.
//   Result channel: each result shows on result for one cycle with strobe
//   high; result.last marks the final result of a command. The receiver
//   cannot stall, so results are never held back.
// Timing:
//   Commands rejected by the early checks answer without a scan. All others scan
//   the table one entry per cycle through a single due-tick comparator
//   and answer once the scan is done. A tick that fires events then reads
//   the slot map in slot order, one slot per cycle, up to the highest live
//   slot; the fired results follow at most one per cycle.
//   The next command may start the cycle after busy falls.
// Reset:
//   arst_n clears the time base and all valid bits; the table is empty
//   immediately, with no clearing pass.
// ----------------------------------------------------------------------------
module deferred_event_scheduler_top #(
	parameter int TABLE_DEPTH = 32,
	parameter int TICK_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dsch_pkg::item_t   item,
	output logic              strobe,
	output dsch_pkg::result_t result
);

	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int SW   = $clog2(TABLE_DEPTH + 1);
	localparam int CNTW = IW + 1;
	localparam int ESW  = SW + 1;
	localparam int CW   = (SW > 6) ? SW : 6;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [1:0]            op_q;
	logic [TICK_WIDTH-1:0] tv_q;
	logic [15:0]           pl_q;
	logic [5:0]            sl_q;
	logic [TICK_WIDTH-1:0] last_tick_q;
	logic [TICK_WIDTH-1:0] tgt_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  rd_s1;
	logic [IW-1:0]         idx_s1;
	logic [SW-1:0]         count_q;
	logic                  free_found_q;
	logic [IW-1:0]         free_idx_q;
	logic [IW-1:0]         hit_idx_q;
	logic [SW-1:0]         maxlive_q;
	logic [ESW-1:0]        es_q;
	logic                  mrd_s1;
	logic [SW-1:0]         mslot_s1;
	logic                  strobe_q;
	dsch_pkg::result_t     result_q;

	logic                  rd_valid;
	logic [TICK_WIDTH-1:0] rd_due;
	logic [SW-1:0]         rd_slot;
	logic [15:0]           rd_payload;
	logic                  rd_cancel;
	logic                  map_live;
	logic [15:0]           map_payload;

	logic                  accept;
	logic                  is_reg;
	logic                  match;
	logic [TICK_WIDTH:0]   sum;
	logic [TICK_WIDTH-1:0] after_due;
	logic [SW-1:0]         rd_slot_m1;
	logic [ESW-1:0]        es_m1;
	logic                  ent_wr;
	logic                  cancel_wr;
	logic                  free_wr;
	logic                  slot_hit;
	logic                  sl_over;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign strobe     = strobe_q;
	assign result     = result_q;
	assign is_reg     = (op_q == dsch_pkg::OP_REG_AT) || (op_q == dsch_pkg::OP_REG_AFTER);
	assign match      = rd_s1 && rd_valid && (rd_due == tgt_q);
	assign sum        = {1'b0, last_tick_q} + {1'b0, tv_q};
	assign after_due  = sum[TICK_WIDTH-1:0];
	assign rd_slot_m1 = rd_slot - SW'(1);
	assign es_m1      = es_q - ESW'(1);
	assign slot_hit   = (CW'(rd_slot) == CW'(sl_q));
	assign sl_over    = (CW'(sl_q) > CW'(count_q));

	assign free_wr   = (state_q == S_SCAN) && (op_q == dsch_pkg::OP_TICK) && match;
	assign ent_wr    = (state_q == S_FIN) && is_reg && free_found_q;
	assign cancel_wr = (state_q == S_FIN) && (op_q == dsch_pkg::OP_CANCEL) &&
	                   (count_q != '0) && !sl_over;

	dsch_entry_mem #(
		.DEPTH (TABLE_DEPTH),
		.TW    (TICK_WIDTH),
		.SW    (SW),
		.IW    (IW)
	) u_entry_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_idx     (cnt_q[IW-1:0]),
		.rd_valid   (rd_valid),
		.rd_due     (rd_due),
		.rd_slot    (rd_slot),
		.rd_payload (rd_payload),
		.rd_cancel  (rd_cancel),
		.wr_en      (ent_wr),
		.wr_idx     (free_idx_q),
		.wr_due     (tgt_q),
		.wr_slot    (count_q + SW'(1)),
		.wr_payload (pl_q),
		.cancel_en  (cancel_wr),
		.cancel_idx (hit_idx_q),
		.free_en    (free_wr),
		.free_idx   (idx_s1)
	);

	dsch_slot_map #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW)
	) u_slot_map (
		.clk        (clk),
		.wr_en      (free_wr),
		.wr_addr    (rd_slot_m1[IW-1:0]),
		.wr_live    (!rd_cancel),
		.wr_payload (rd_payload),
		.rd_addr    (es_m1[IW-1:0]),
		.rd_live    (map_live),
		.rd_payload (map_payload)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= dsch_pkg::OP_TICK;
			tv_q         <= '0;
			pl_q         <= '0;
			sl_q         <= '0;
			last_tick_q  <= '0;
			tgt_q        <= '0;
			cnt_q        <= '0;
			rd_s1        <= 1'b0;
			idx_s1       <= '0;
			count_q      <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			hit_idx_q    <= '0;
			maxlive_q    <= '0;
			es_q         <= '0;
			mrd_s1       <= 1'b0;
			mslot_s1     <= '0;
			strobe_q     <= 1'b0;
			result_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					strobe_q <= 1'b0;
					if (accept) begin
						op_q    <= item.op;
						tv_q    <= TICK_WIDTH'(item.tick_value);
						pl_q    <= item.payload;
						sl_q    <= item.slot;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					// early checks; anything rejected here never scans
					logic bad;
					bad = 1'b0;
					tgt_q <= (op_q == dsch_pkg::OP_REG_AFTER) ? after_due : tv_q;
					case (op_q)
						dsch_pkg::OP_TICK: begin
							if (tv_q != '0)
								bad = !(tv_q > last_tick_q);
							else
								bad = (last_tick_q != '0);
							if (!bad)
								last_tick_q <= tv_q;
						end
						dsch_pkg::OP_REG_AT: bad = !(tv_q > last_tick_q);
						dsch_pkg::OP_REG_AFTER: begin
							// a wrapped sum is not above last_tick
							bad = (tv_q == '0) || !(after_due > last_tick_q);
						end
						default: bad = (sl_q == '0);
					endcase
					cnt_q        <= '0;
					rd_s1        <= 1'b0;
					count_q      <= '0;
					free_found_q <= 1'b0;
					maxlive_q    <= '0;
					strobe_q     <= bad;
					if (bad) begin
						result_q <= '{dsch_pkg::ST_REJECT, 32'd0, 6'd0, 16'd0, 1'b1};
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					strobe_q <= 1'b0;
					if (cnt_q < CNTW'(TABLE_DEPTH)) begin
						cnt_q  <= cnt_q + CNTW'(1);
						rd_s1  <= 1'b1;
						idx_s1 <= cnt_q[IW-1:0];
					end else begin
						rd_s1 <= 1'b0;
					end
					if (rd_s1) begin
						if (!rd_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
						if (match) begin
							count_q <= count_q + SW'(1);
							if (slot_hit)
								hit_idx_q <= idx_s1;
							if (!rd_cancel && (rd_slot > maxlive_q))
								maxlive_q <= rd_slot;
						end
					end
					// last read data is handled in this cycle
					if (cnt_q == CNTW'(TABLE_DEPTH))
						state_q <= S_FIN;
				end
				S_FIN: begin
					case (op_q)
						dsch_pkg::OP_TICK: begin
							strobe_q <= (maxlive_q == '0);
							if (maxlive_q == '0) begin
								result_q <= '{dsch_pkg::ST_NONE, 32'(tgt_q), 6'd0, 16'd0,
								              1'b1};
								state_q  <= S_IDLE;
							end else begin
								es_q    <= ESW'(1);
								mrd_s1  <= 1'b0;
								state_q <= S_EMIT;
							end
						end
						dsch_pkg::OP_CANCEL: begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
							if ((count_q != '0) && sl_over)
								result_q <= '{dsch_pkg::ST_REJECT, 32'd0, 6'd0, 16'd0, 1'b1};
							else
								result_q <= '{dsch_pkg::ST_ACCEPT, 32'(tgt_q), sl_q, 16'd0,
								              1'b1};
						end
						default: begin
							strobe_q <= 1'b1;
							state_q  <= S_IDLE;
							if (free_found_q)
								result_q <= '{dsch_pkg::ST_ACCEPT, 32'(tgt_q),
								              6'(count_q + SW'(1)), 16'd0, 1'b1};
							else
								result_q <= '{dsch_pkg::ST_FULL, 32'd0, 6'd0, 16'd0, 1'b1};
						end
					endcase
				end
				S_EMIT: begin
					if (es_q <= ESW'(maxlive_q)) begin
						es_q     <= es_q + ESW'(1);
						mrd_s1   <= 1'b1;
						mslot_s1 <= es_q[SW-1:0];
					end else begin
						mrd_s1 <= 1'b0;
					end
					strobe_q <= mrd_s1 && map_live;
					if (mrd_s1 && map_live) begin
						result_q <= '{dsch_pkg::ST_FIRED, 32'(tgt_q), 6'(mslot_s1),
						              map_payload, (mslot_s1 == maxlive_q)};
					end
					if (mrd_s1 && (mslot_s1 == maxlive_q))
						state_q <= S_IDLE;
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_single_final: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (result.status != dsch_pkg::ST_FIRED)) |-> result.last)
		else $error("non-fired result without last");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> busy)
		else $error("non-final result while idle");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: deferred event scheduler
// Sends register, cancel and tick commands through the start/busy channel,
// predicts every result from a shadow copy of the event table, and checks
// each strobed result in order against the predicted ones.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH        = 32;
	localparam int DRAIN_CYCLES = 100;
	localparam int DRAIN_LIMIT  = 5000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	dsch_pkg::item_t   item;
	logic              strobe;
	dsch_pkg::result_t result;

	// shadow event table
	logic [31:0] now_tick;
	bit          ev_valid[DEPTH];
	logic [31:0] ev_due[DEPTH];
	logic [5:0]  ev_slot[DEPTH];
	logic [15:0] ev_payload[DEPTH];
	bit          ev_cancelled[DEPTH];

	dsch_pkg::result_t due_results[$];
	dsch_pkg::result_t exp_r;
	int                errors;
	int                n_items;
	int                n_checked;
	int                n_fired;
	int                idle_pct;

	deferred_event_scheduler_top #(
		.TABLE_DEPTH(DEPTH),
		.TICK_WIDTH (32)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.strobe(strobe),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int count_at_tick(logic [31:0] t);
		int n;
		n = 0;
		for (int i = 0; i < DEPTH; i++)
			if (ev_valid[i] && ev_due[i] == t)
				n++;
		return n;
	endfunction

	task automatic add_result(logic [2:0] st, logic [31:0] due, logic [5:0] sl,
			logic [15:0] pl, logic lst);
		dsch_pkg::result_t r;
		r.status      = st;
		r.due_tick    = due;
		r.slot_out    = sl;
		r.payload_out = pl;
		r.last        = lst;
		due_results.push_back(r);
	endtask

	task automatic schedule_event(logic [31:0] due, logic [15:0] pl);
		int         free_idx;
		logic [5:0] sl;
		free_idx = -1;
		if (due <= now_tick) begin
			add_result(dsch_pkg::ST_REJECT, '0, '0, '0, 1'b1);
			return;
		end
		for (int i = DEPTH - 1; i >= 0; i--)
			if (!ev_valid[i])
				free_idx = i;
		if (free_idx < 0) begin
			add_result(dsch_pkg::ST_FULL, '0, '0, '0, 1'b1);
			return;
		end
		sl = 6'(count_at_tick(due) + 1);
		ev_valid[free_idx]     = 1'b1;
		ev_due[free_idx]       = due;
		ev_slot[free_idx]      = sl;
		ev_payload[free_idx]   = pl;
		ev_cancelled[free_idx] = 1'b0;
		add_result(dsch_pkg::ST_ACCEPT, due, sl, '0, 1'b1);
	endtask

	task automatic advance_time(logic [31:0] t);
		int total;
		int live;
		int fired;
		if ((t != 0) ? (t <= now_tick) : (t < now_tick)) begin
			add_result(dsch_pkg::ST_REJECT, '0, '0, '0, 1'b1);
			return;
		end
		now_tick = t;
		total = count_at_tick(t);
		live  = 0;
		fired = 0;
		for (int i = 0; i < DEPTH; i++)
			if (ev_valid[i] && ev_due[i] == t && !ev_cancelled[i])
				live++;
		// slots within one tick are unique, so walking them in order gives
		// registration order
		for (int s = 1; s <= total; s++)
			for (int i = 0; i < DEPTH; i++)
				if (ev_valid[i] && ev_due[i] == t && ev_slot[i] == s && !ev_cancelled[i]) begin
					fired++;
					add_result(dsch_pkg::ST_FIRED, t, 6'(s), ev_payload[i], fired == live);
				end
		for (int i = 0; i < DEPTH; i++)
			if (ev_valid[i] && ev_due[i] == t)
				ev_valid[i] = 1'b0;
		if (live == 0)
			add_result(dsch_pkg::ST_NONE, t, '0, '0, 1'b1);
	endtask

	task automatic cancel_event(logic [31:0] due, logic [5:0] sl);
		int total;
		if (sl == 0) begin
			add_result(dsch_pkg::ST_REJECT, '0, '0, '0, 1'b1);
			return;
		end
		total = count_at_tick(due);
		if (total != 0 && sl > total) begin
			add_result(dsch_pkg::ST_REJECT, '0, '0, '0, 1'b1);
			return;
		end
		for (int i = 0; i < DEPTH; i++)
			if (ev_valid[i] && ev_due[i] == due && ev_slot[i] == sl)
				ev_cancelled[i] = 1'b1;
		add_result(dsch_pkg::ST_ACCEPT, due, sl, '0, 1'b1);
	endtask

	task automatic predict_item(dsch_pkg::item_t it);
		case (it.op)
			dsch_pkg::OP_TICK: begin
				advance_time(it.tick_value);
			end
			dsch_pkg::OP_REG_AT: begin
				schedule_event(it.tick_value, it.payload);
			end
			dsch_pkg::OP_REG_AFTER: begin
				if (it.tick_value == 0)
					add_result(dsch_pkg::ST_REJECT, '0, '0, '0, 1'b1);
				else
					schedule_event(now_tick + it.tick_value, it.payload);
			end
			default: begin
				cancel_event(it.tick_value, it.slot);
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge that takes the transaction,
	// with start still high so a following item can go back to back.
	task automatic send_item(logic [1:0] op, logic [31:0] tv, logic [15:0] pl,
			logic [5:0] sl);
		dsch_pkg::item_t it;
		it.op         = op;
		it.tick_value = tv;
		it.payload    = pl;
		it.slot       = sl;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		predict_item(it);
		n_items++;
	endtask

	task automatic test_corner_cases();
		send_item(dsch_pkg::OP_TICK, 32'd0, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_REG_AT, 32'd0, 16'h1111, 6'd0);
		send_item(dsch_pkg::OP_REG_AFTER, 32'd0, 16'h2222, 6'd0);
		send_item(dsch_pkg::OP_REG_AT, 32'd5, 16'hFFFF, 6'd63);
		send_item(dsch_pkg::OP_REG_AT, 32'd5, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_REG_AFTER, 32'd5, 16'hA5A5, 6'd21);
		send_item(dsch_pkg::OP_REG_AT, 32'd6, 16'h5A5A, 6'd42);
		send_item(dsch_pkg::OP_CANCEL, 32'd5, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_CANCEL, 32'd5, 16'h0000, 6'd4);
		send_item(dsch_pkg::OP_CANCEL, 32'd5, 16'h0000, 6'd2);
		send_item(dsch_pkg::OP_CANCEL, 32'd5, 16'hFFFF, 6'd2);
		send_item(dsch_pkg::OP_CANCEL, 32'd9, 16'h0000, 6'd63);
		send_item(dsch_pkg::OP_TICK, 32'd3, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_TICK, 32'd3, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_TICK, 32'd0, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_TICK, 32'd5, 16'h0000, 6'd0);
		// delay wraps past the tick width
		send_item(dsch_pkg::OP_REG_AFTER, 32'hFFFF_FFFF, 16'h3333, 6'd0);
		send_item(dsch_pkg::OP_REG_AT, 32'd5, 16'h4444, 6'd0);
		send_item(dsch_pkg::OP_CANCEL, 32'd6, 16'h0000, 6'd1);
		send_item(dsch_pkg::OP_TICK, 32'd6, 16'h0000, 6'd0);
		send_item(dsch_pkg::OP_CANCEL, 32'd6, 16'h0000, 6'd1);
		send_item(dsch_pkg::OP_TICK, 32'd7, 16'h0000, 6'd0);
	endtask

	task automatic test_table_full();
		logic [31:0] due;
		due = now_tick + 32'd3;
		for (int i = 0; i < DEPTH; i++)
			if (i % 2 == 0)
				send_item(dsch_pkg::OP_REG_AT, due, 16'($urandom), 6'($urandom));
			else
				send_item(dsch_pkg::OP_REG_AFTER, 32'd3, 16'($urandom), 6'($urandom));
		send_item(dsch_pkg::OP_REG_AT, due, 16'($urandom), 6'd0);
		send_item(dsch_pkg::OP_REG_AFTER, 32'd1, 16'($urandom), 6'd0);
		send_item(dsch_pkg::OP_CANCEL, due, 16'd0, 6'(DEPTH + 1));
		// every entry fires from one tick
		send_item(dsch_pkg::OP_TICK, due, 16'd0, 6'd0);
	endtask

	task automatic test_skipped_tick();
		logic [31:0] base;
		base = now_tick;
		send_item(dsch_pkg::OP_REG_AT, base + 32'd1, 16'($urandom), 6'd0);
		send_item(dsch_pkg::OP_REG_AT, base + 32'd2, 16'($urandom), 6'd0);
		send_item(dsch_pkg::OP_TICK, base + 32'd3, 16'd0, 6'd0);
		// both entries stay behind; the first can still be cancelled
		send_item(dsch_pkg::OP_CANCEL, base + 32'd1, 16'd0, 6'd1);
		send_item(dsch_pkg::OP_CANCEL, base + 32'd2, 16'd0, 6'd2);
	endtask

	task automatic test_random(int pct, int quota);
		int          first;
		int          cnt;
		logic [1:0]  op;
		logic [31:0] base;
		logic [31:0] tv;
		logic [31:0] d;
		first    = n_items;
		idle_pct = pct;
		while (n_items - first < quota) begin
			if ($urandom_range(99) < 20) begin
				// noise, kept from parking entries at far ticks
				op = 2'($urandom_range(3));
				case (op)
					dsch_pkg::OP_TICK:
						tv = (now_tick == 0) ? 32'd0 : now_tick - ($urandom % now_tick);
					dsch_pkg::OP_REG_AT:
						tv = $urandom % (now_tick + 32'd1);
					dsch_pkg::OP_REG_AFTER:
						tv = (now_tick == 0 || $urandom_range(1)) ? 32'd0 :
							32'hFFFF_FFFF - ($urandom % now_tick);
					default:
						tv = $urandom;
				endcase
				send_item(op, tv, 16'($urandom), 6'($urandom));
			end else begin
				base = now_tick;
				repeat ($urandom_range(6, 1)) begin
					d = 32'($urandom_range(4, 1));
					if ($urandom_range(1))
						send_item(dsch_pkg::OP_REG_AT, base + d, 16'($urandom),
							6'($urandom));
					else
						send_item(dsch_pkg::OP_REG_AFTER, d, 16'($urandom), 6'($urandom));
				end
				repeat ($urandom_range(2, 0)) begin
					d = base + 32'($urandom_range(4, 1));
					cnt = count_at_tick(d);
					send_item(dsch_pkg::OP_CANCEL, d, 16'($urandom),
						6'($urandom_range(cnt + 1, 0)));
				end
				// now and then a tick is skipped and its entries stay
				for (int k = 1; k <= 4; k++)
					if ($urandom_range(19) != 0)
						send_item(dsch_pkg::OP_TICK, base + 32'(k), 16'($urandom),
							6'($urandom));
			end
		end
	endtask

	task automatic test_far_ticks();
		idle_pct = 0;
		send_item(dsch_pkg::OP_REG_AFTER, 32'hFFFF_FFFF - now_tick, 16'hC3C3, 6'd0);
		send_item(dsch_pkg::OP_REG_AT, 32'hFFFF_FFFF, 16'h3C3C, 6'd0);
		send_item(dsch_pkg::OP_REG_AT, 32'h8000_0000, 16'h8001, 6'd0);
		send_item(dsch_pkg::OP_TICK, 32'h8000_0000, 16'd0, 6'd0);
		send_item(dsch_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0, 6'd0);
		send_item(dsch_pkg::OP_REG_AFTER, 32'd1, 16'h7777, 6'd0);
		send_item(dsch_pkg::OP_REG_AT, 32'hFFFF_FFFF, 16'h8888, 6'd0);
		send_item(dsch_pkg::OP_TICK, 32'd0, 16'd0, 6'd0);
	endtask

	// result checker; results cannot be held off, so every strobe counts
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				if (errors < 20)
					$display("%0t: unexpected result status=%0d due=%0d slot=%0d %s%h last=%b",
						$time, result.status, result.due_tick, result.slot_out,
						"payload=", result.payload_out, result.last);
				errors++;
			end else begin
				exp_r = due_results.pop_front();
				if (result.status !== exp_r.status || result.due_tick !== exp_r.due_tick ||
						result.slot_out !== exp_r.slot_out ||
						result.payload_out !== exp_r.payload_out ||
						result.last !== exp_r.last) begin
					if (errors < 20) begin
						$display("%0t: mismatch expected status=%0d due=%0d slot=%0d %s%h last=%b",
							$time, exp_r.status, exp_r.due_tick, exp_r.slot_out,
							"payload=", exp_r.payload_out, exp_r.last);
						$display("%0t: mismatch actual   status=%0d due=%0d slot=%0d %s%h last=%b",
							$time, result.status, result.due_tick, result.slot_out,
							"payload=", result.payload_out, result.last);
					end
					errors++;
				end
				n_checked++;
				if (exp_r.status == dsch_pkg::ST_FIRED)
					n_fired++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d results still expected", $time, due_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int waited;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		idle_pct  = 0;
		errors    = 0;
		n_items   = 0;
		n_checked = 0;
		n_fired   = 0;
		now_tick  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			ev_valid[i]     = 1'b0;
			ev_due[i]       = '0;
			ev_slot[i]      = '0;
			ev_payload[i]   = '0;
			ev_cancelled[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_table_full();
		test_skipped_tick();
		test_random(32, 16);
		test_random(77, 16);
		test_random(0, 16);
		test_far_ticks();
		start <= 1'b0;

		waited = 0;
		while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_results.size());
			errors++;
		end

		$display("Sent %0d commands: corner cases, a full table, skipped ticks, random bursts",
			n_items);
		$display("under three idle patterns, far ticks; %0d results checked, %0d fired events.",
			n_checked, n_fired);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
